/* src/qvr_pkg.sv */
// shared constants and types for the quaternion vector rotator
package qvr_pkg;

    localparam int VECTOR_WIDTH = 16;
    localparam int QUAT_W       = 16;
    localparam int OUT_W        = 18;
    localparam int QFRAC        = 14;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = QUAT_W;

    // u x v products and their differences
    localparam int PROD_W  = QUAT_W + VECTOR_WIDTH;
    localparam int CROSS_W = PROD_W + 1;
    // quaternion times cross product
    localparam int PROD2_W = QUAT_W + CROSS_W;
    // final accumulator at scale 2^(2*QFRAC)
    localparam int SUM_W   = PROD2_W + 4;
    localparam int SHIFT   = 2 * QFRAC;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(1) << QFRAC;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUAT_X = 2'd0,
        CFG_QUAT_Y = 2'd1,
        CFG_QUAT_Z = 2'd2,
        CFG_QUAT_W = 2'd3
    } cfg_idx_t;

endpackage

/* src/quaternion_vector_rotate.sv */
// quaternion vector rotator: five-stage pipeline computing v + 2w(u x v) + 2u x (u x v)
// One vector enters per clock cycle and its rotated result appears on rot_x/rot_y/rot_z
// with done high; busy is always low, so items may be issued back to back without
// limit. The depth comes from the two chained multiplier levels (u x v, then
// u x (u x v) and w(u x v)), each followed by a register, plus the cross-product
// subtraction, the wide accumulate and the final round-and-saturate stage. The result
// is held for one cycle only, so the receiver must take it when done is high. The
// quaternion registers (Q2.14) reset to identity and should only be written while no
// item is in flight.
module quaternion_vector_rotate
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [qvr_pkg::VECTOR_WIDTH-1:0] vec_x,
    input  logic signed [qvr_pkg::VECTOR_WIDTH-1:0] vec_y,
    input  logic signed [qvr_pkg::VECTOR_WIDTH-1:0] vec_z,
    output logic                                  done,
    output logic signed [qvr_pkg::OUT_W-1:0]      rot_x,
    output logic signed [qvr_pkg::OUT_W-1:0]      rot_y,
    output logic signed [qvr_pkg::OUT_W-1:0]      rot_z,
    input  logic                                  cfg_we,
    input  logic [qvr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [qvr_pkg::CFG_DATA_W-1:0]        cfg_data
);

    import qvr_pkg::*;

    localparam int LAT = 5;

    logic signed [QUAT_W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;

    logic [LAT-1:0] vld_reg, vld_next;

    // stage 1: six products of u x v
    logic signed [PROD_W-1:0] p1_reg [6];
    logic signed [PROD_W-1:0] p1_next [6];
    logic signed [VECTOR_WIDTH-1:0] v1_reg [3];

    // stage 2: a = u x v
    logic signed [CROSS_W-1:0] a2_reg [3];
    logic signed [CROSS_W-1:0] a2_next [3];
    logic signed [VECTOR_WIDTH-1:0] v2_reg [3];

    // stage 3: u x a products and w*a
    logic signed [PROD2_W-1:0] p3_reg [9];
    logic signed [PROD2_W-1:0] p3_next [9];
    logic signed [VECTOR_WIDTH-1:0] v3_reg [3];

    // stage 4: accumulated sums
    logic signed [SUM_W-1:0] s4_reg [3];
    logic signed [SUM_W-1:0] s4_next [3];

    // stage 5: output registers
    logic signed [OUT_W-1:0] r5_reg [3];
    logic signed [OUT_W-1:0] r5_next [3];

    logic accept;

    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] r;
        r = (s + (SUM_W'(1) <<< (SHIFT - 1))) >>> SHIFT;
        if (r > SUM_W'(OUT_MAX))
            round_sat = OUT_MAX;
        else if (r < SUM_W'(OUT_MIN))
            round_sat = OUT_MIN;
        else
            round_sat = r[OUT_W-1:0];
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
            qw_reg <= QUAT_ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_QUAT_X: qx_reg <= cfg_data;
                CFG_QUAT_Y: qy_reg <= cfg_data;
                CFG_QUAT_Z: qz_reg <= cfg_data;
                CFG_QUAT_W: qw_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], accept};

        p1_next[0] = PROD_W'(qy_reg) * PROD_W'(vec_z);
        p1_next[1] = PROD_W'(qz_reg) * PROD_W'(vec_y);
        p1_next[2] = PROD_W'(qz_reg) * PROD_W'(vec_x);
        p1_next[3] = PROD_W'(qx_reg) * PROD_W'(vec_z);
        p1_next[4] = PROD_W'(qx_reg) * PROD_W'(vec_y);
        p1_next[5] = PROD_W'(qy_reg) * PROD_W'(vec_x);

        a2_next[0] = CROSS_W'(p1_reg[0]) - CROSS_W'(p1_reg[1]);
        a2_next[1] = CROSS_W'(p1_reg[2]) - CROSS_W'(p1_reg[3]);
        a2_next[2] = CROSS_W'(p1_reg[4]) - CROSS_W'(p1_reg[5]);

        // b = u x a split into products, then w * a
        p3_next[0] = PROD2_W'(qy_reg) * PROD2_W'(a2_reg[2]);
        p3_next[1] = PROD2_W'(qz_reg) * PROD2_W'(a2_reg[1]);
        p3_next[2] = PROD2_W'(qz_reg) * PROD2_W'(a2_reg[0]);
        p3_next[3] = PROD2_W'(qx_reg) * PROD2_W'(a2_reg[2]);
        p3_next[4] = PROD2_W'(qx_reg) * PROD2_W'(a2_reg[1]);
        p3_next[5] = PROD2_W'(qy_reg) * PROD2_W'(a2_reg[0]);
        p3_next[6] = PROD2_W'(qw_reg) * PROD2_W'(a2_reg[0]);
        p3_next[7] = PROD2_W'(qw_reg) * PROD2_W'(a2_reg[1]);
        p3_next[8] = PROD2_W'(qw_reg) * PROD2_W'(a2_reg[2]);

        for (int i = 0; i < 3; i++)
        begin
            s4_next[i] = (SUM_W'(v3_reg[i]) <<< SHIFT)
                       + (SUM_W'(p3_reg[6 + i]) <<< 1)
                       + ((SUM_W'(p3_reg[2 * i]) - SUM_W'(p3_reg[2 * i + 1])) <<< 1);
            r5_next[i] = round_sat(s4_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        p1_reg    <= p1_next;
        v1_reg[0] <= vec_x;
        v1_reg[1] <= vec_y;
        v1_reg[2] <= vec_z;
        a2_reg    <= a2_next;
        v2_reg    <= v1_reg;
        p3_reg    <= p3_next;
        v3_reg    <= v2_reg;
        s4_reg    <= s4_next;
        r5_reg    <= r5_next;
    end

    assign done  = vld_reg[LAT-1];
    assign rot_x = r5_reg[0];
    assign rot_y = r5_reg[1];
    assign rot_z = r5_reg[2];

    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("item lost in pipeline");

    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 5))
        else $error("result without matching item");

    a_zero_vec : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && vec_x == '0 && vec_y == '0 && vec_z == '0)
        |-> ##5 (rot_x == '0 && rot_y == '0 && rot_z == '0))
        else $error("zero vector did not rotate to zero");

endmodule

/* test/tb_top.sv */
// self-checking testbench for quaternion_vector_rotate: random vectors under a range of quaternions
module tb_top;

    import qvr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 12;

    typedef logic signed [VECTOR_WIDTH-1:0] vec_t;
    typedef logic signed [QUAT_W-1:0]       quat_t;
    typedef logic signed [OUT_W-1:0]        rot_t;

    typedef struct {
        rot_t x;
        rot_t y;
        rot_t z;
    } rotated_vec_t;

    class rotation_checker;
        quat_t        qx, qy, qz, qw;
        rotated_vec_t expected_rotations[$];
        int unsigned  errors;

        function new();
            qx = '0;
            qy = '0;
            qz = '0;
            qw = QUAT_ONE;
            errors = 0;
        endfunction

        function void load_quat(cfg_idx_t idx, quat_t val);
            case (idx)
                CFG_QUAT_X: qx = val;
                CFG_QUAT_Y: qy = val;
                CFG_QUAT_Z: qz = val;
                CFG_QUAT_W: qw = val;
                default: ;
            endcase
        endfunction

        // drop the 2*QFRAC fraction bits, rounding half up, then clamp to 18 bits
        function rot_t round_sat(longint acc);
            longint r;
            r = (acc + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
            if (r > longint'(OUT_MAX))
                r = longint'(OUT_MAX);
            if (r < longint'(OUT_MIN))
                r = longint'(OUT_MIN);
            return rot_t'(r);
        endfunction

        function void note_vector(vec_t vx, vec_t vy, vec_t vz);
            longint ux, uy, uz, w, px, py, pz;
            longint ax, ay, az, bx, by, bz;
            rotated_vec_t r;
            ux = qx;
            uy = qy;
            uz = qz;
            w  = qw;
            px = vx;
            py = vy;
            pz = vz;
            // u x v at scale 2^14, then u x (u x v) and the sums at scale 2^28, everything exact
            ax = uy * pz - uz * py;
            ay = uz * px - ux * pz;
            az = ux * py - uy * px;
            bx = uy * az - uz * ay;
            by = uz * ax - ux * az;
            bz = ux * ay - uy * ax;
            r.x = round_sat((px <<< SHIFT) + 2 * w * ax + 2 * bx);
            r.y = round_sat((py <<< SHIFT) + 2 * w * ay + 2 * by);
            r.z = round_sat((pz <<< SHIFT) + 2 * w * az + 2 * bz);
            expected_rotations.push_back(r);
        endfunction

        function void check_rotation(rot_t rx, rot_t ry, rot_t rz);
            rotated_vec_t e;
            if (expected_rotations.size() == 0)
            begin
                $error("unexpected result %0d %0d %0d", rx, ry, rz);
                errors++;
                return;
            end
            e = expected_rotations.pop_front();
            if (rx !== e.x)
            begin
                $error("rot_x: expected %0d, got %0d", e.x, rx);
                errors++;
            end
            if (ry !== e.y)
            begin
                $error("rot_y: expected %0d, got %0d", e.y, ry);
                errors++;
            end
            if (rz !== e.z)
            begin
                $error("rot_z: expected %0d, got %0d", e.z, rz);
                errors++;
            end
        endfunction

        function int pending();
            return expected_rotations.size();
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    vec_t     vec_x, vec_y, vec_z;
    logic     done;
    rot_t     rot_x, rot_y, rot_z;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    quat_t    cfg_data;

    rotation_checker rotations = new();
    int unsigned     cycle_count = 0;
    int              idle_pct = 0;

    quaternion_vector_rotate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .done      (done),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            rotations.check_rotation(rot_x, rot_y, rot_z);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic send_vector(vec_t vx, vec_t vy, vec_t vz);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        vec_x <= vx;
        vec_y <= vy;
        vec_z <= vz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rotations.note_vector(vx, vy, vz);
    endtask

    // stop issuing and wait until every rotated item is back
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (rotations.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, quat_t val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        rotations.load_quat(idx, val);
    endtask

    task automatic set_quat(quat_t x, quat_t y, quat_t z, quat_t w);
        write_reg(CFG_QUAT_X, x);
        write_reg(CFG_QUAT_Y, y);
        write_reg(CFG_QUAT_Z, z);
        write_reg(CFG_QUAT_W, w);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic quat_t extreme_quat();
        case ($urandom_range(3))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return '0;
            default: return QUAT_ONE;
        endcase
    endfunction

    task automatic random_quat(int kind);
        real  r[4];
        real  norm;
        quat_t q[4];
        case (kind)
            0:
            begin
                // near-unit rotation, results mostly stay in range
                norm = 0.0;
                foreach (r[i])
                begin
                    r[i] = real'($urandom_range(2000)) - 1000.0;
                    norm += r[i] * r[i];
                end
                norm = $sqrt(norm);
                if (norm < 1.0)
                    set_quat('0, '0, '0, QUAT_ONE);
                else
                begin
                    foreach (q[i])
                        q[i] = quat_t'($rtoi(r[i] / norm * 16383.0));
                    set_quat(q[0], q[1], q[2], q[3]);
                end
            end
            1: set_quat(quat_t'($urandom), quat_t'($urandom), quat_t'($urandom),
                        quat_t'($urandom));
            default: set_quat(extreme_quat(), extreme_quat(), extreme_quat(),
                              extreme_quat());
        endcase
    endtask

    function automatic vec_t random_component();
        case ($urandom_range(11))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return vec_t'(int'($urandom_range(2)) - 1);
            default: return vec_t'($urandom);
        endcase
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        vec_x     = '0;
        vec_y     = '0;
        vec_z     = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_QUAT_X;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // identity after reset
        send_vector(16'sd0, 16'sd0, 16'sd0);
        send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_vector(16'sh8000, 16'sh8000, 16'sh8000);
        send_vector(16'sh7fff, 16'sh8000, 16'sd1);
        send_vector(-16'sd1, 16'sd0, -16'sd1);
        drain();

        // quarter turn about z
        set_quat('0, '0, 16'sd11585, 16'sd11585);
        send_vector(16'sh7fff, 16'sd0, 16'sd0);
        send_vector(16'sd0, 16'sh8000, 16'sd12345);
        drain();

        // large non-unit quaternions drive both saturation limits
        set_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_vector(16'sh8000, 16'sh8000, 16'sh8000);
        send_vector(16'sh7fff, 16'sh8000, 16'sd0);
        drain();
        set_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_vector(16'sh7fff, 16'sd1, 16'sh8000);
        send_vector(16'sh8000, 16'sh8000, 16'sh8000);
        drain();
        set_quat('0, '0, '0, '0);
        send_vector(16'sh7fff, 16'sh8000, 16'sd100);
        drain();
        set_quat(16'sh7fff, '0, '0, 16'sh8000);
        send_vector(16'sd0, 16'sh7fff, 16'sh8000);
        send_vector(16'sh8000, 16'sd1234, -16'sd1);
        drain();

        for (int phase = 0; phase < 9; phase++)
        begin
            random_quat(phase % 3 == 1 ? 1 : (phase == 4 || phase == 7 ? 2 : 0));
            // one phase runs back to back with no gaps
            idle_pct = (phase == 3) ? 0 : 31;
            repeat (150)
                send_vector(random_component(), random_component(), random_component());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (rotations.errors == 0 && rotations.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
